// ===== rtl/nsac_pkg.sv =====
// shared constants for the nearest-neighbor scaler with alpha blend
// field widths, command and entry kind codes, register indexes, background color
// no dependencies
package nsac_pkg;

   // default sizing
   localparam int MAX_SOURCE_DIM_DEF = 256;
   localparam int MAX_OUTPUT_DIM_DEF = 2048;
   localparam int QUEUE_DEPTH        = 2;

   // port field widths
   localparam int CMD_W     = 1;
   localparam int XY_W      = 11;
   localparam int CHAN_W    = 8;
   localparam int RGB_W     = 24;
   localparam int RGBA_W    = 32;
   localparam int SRC_CFG_W = 9;
   localparam int OUT_CFG_W = 12;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 12;
   localparam int KIND_W    = 2;

   // commands on the request channel
   localparam logic [CMD_W-1:0] CMD_STORE = 1'b0;
   localparam logic [CMD_W-1:0] CMD_FETCH = 1'b1;

   // status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   // kinds of work handed from front to back
   localparam logic [KIND_W-1:0] KIND_STORE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FETCH = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_HEIGHT = 2'd3;

   // background color and full opacity
   localparam logic [CHAN_W-1:0] BG_RED     = 8'd29;
   localparam logic [CHAN_W-1:0] BG_GREEN   = 8'd29;
   localparam logic [CHAN_W-1:0] BG_BLUE    = 8'd39;
   localparam logic [CHAN_W-1:0] FULL_ALPHA = 8'd255;

   // size register reset value
   localparam int DIM_RESET = 256;

endpackage

// ===== rtl/nearest_scale_alpha_composite_core.sv =====
// top level of the nearest-neighbor scaler with alpha blend
// holds the size registers and connects front, queue and back
// depends on nsac_pkg, nsac_front, nsac_queue, nsac_back
//
//   channel   direction  handshake            payload
//   req       in         push / full          cmd, x/y coord, red/green/blue/alpha in
//   rsp       out        empty / pop          pixel_rgb, status
//   csr       in         valid / ready        index, wdata (ready is always high)
//
// a store is written in the back part straight from the idle state; a fetch runs the
// one-bit-per-cycle coordinate divider, then the address, blend and output states around
// the registered frame ram read; an out-of-range fetch is answered from the idle state
// reset clears the queue, sequencer and result valid, and loads the size registers;
// the frame ram is not cleared
// requests queue in front of the back part, and the back part stalls when a result
// is still waiting to be popped
module nearest_scale_alpha_composite_core #(
   parameter int MAX_SOURCE_DIM = nsac_pkg::MAX_SOURCE_DIM_DEF,
   parameter int MAX_OUTPUT_DIM = nsac_pkg::MAX_OUTPUT_DIM_DEF,
   localparam int SDW = $clog2(MAX_SOURCE_DIM + 1),
   localparam int ODW = $clog2(MAX_OUTPUT_DIM + 1),
   localparam int AW  = (MAX_SOURCE_DIM > 1) ? $clog2(MAX_SOURCE_DIM * MAX_SOURCE_DIM) : 1,
   localparam int PW  = nsac_pkg::XY_W + SDW,
   localparam int EW  = nsac_pkg::KIND_W + AW + 2 * PW + nsac_pkg::RGBA_W
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [nsac_pkg::CMD_W-1:0]     req_cmd,
   input  logic [nsac_pkg::XY_W-1:0]      req_x_coord,
   input  logic [nsac_pkg::XY_W-1:0]      req_y_coord,
   input  logic [nsac_pkg::CHAN_W-1:0]    req_red_in,
   input  logic [nsac_pkg::CHAN_W-1:0]    req_green_in,
   input  logic [nsac_pkg::CHAN_W-1:0]    req_blue_in,
   input  logic [nsac_pkg::CHAN_W-1:0]    req_alpha_in,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [nsac_pkg::RGB_W-1:0]     rsp_pixel_rgb,
   output logic                           rsp_status,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [nsac_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nsac_pkg::CSR_DAT_W-1:0] csr_wdata
);

   import nsac_pkg::*;

   localparam int SRC_RESET = (DIM_RESET < MAX_SOURCE_DIM) ? DIM_RESET : MAX_SOURCE_DIM;
   localparam int OUT_RESET = (DIM_RESET < MAX_OUTPUT_DIM) ? DIM_RESET : MAX_OUTPUT_DIM;

   // saturate a written size to 1..max
   function automatic logic [31:0] clamp_dim(input logic [31:0] v, input int maxv);
      logic [31:0] r;
      if (v == 32'd0) begin
         r = 32'd1;
      end else if (v > 32'(maxv)) begin
         r = 32'(maxv);
      end else begin
         r = v;
      end
      return r;
   endfunction

   logic [SDW-1:0]  src_width_ff, src_width_in;
   logic [SDW-1:0]  src_height_ff, src_height_in;
   logic [ODW-1:0]  out_width_ff, out_width_in;
   logic [ODW-1:0]  out_height_ff, out_height_in;
   logic            csr_write;
   logic [SDW-1:0]  src_value;
   logic [ODW-1:0]  out_value;
   logic            q_push, q_full, q_pop, q_empty;
   logic [EW-1:0]   q_wdata, q_rdata;

   // configuration write transfer
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign src_value = SDW'(clamp_dim(32'(csr_wdata[SRC_CFG_W-1:0]), MAX_SOURCE_DIM));
   assign out_value = ODW'(clamp_dim(32'(csr_wdata[OUT_CFG_W-1:0]), MAX_OUTPUT_DIM));

   always_comb begin
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      out_width_in  = out_width_ff;
      out_height_in = out_height_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SOURCE_WIDTH:  src_width_in  = src_value;
            CSR_SOURCE_HEIGHT: src_height_in = src_value;
            CSR_OUTPUT_WIDTH:  out_width_in  = out_value;
            CSR_OUTPUT_HEIGHT: out_height_in = out_value;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SDW'(SRC_RESET);
         src_height_ff <= SDW'(SRC_RESET);
         out_width_ff  <= ODW'(OUT_RESET);
         out_height_ff <= ODW'(OUT_RESET);
      end else begin
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
         out_width_ff  <= out_width_in;
         out_height_ff <= out_height_in;
      end
   end

   // request classification
   nsac_front #(
      .MAX_SOURCE_DIM (MAX_SOURCE_DIM),
      .MAX_OUTPUT_DIM (MAX_OUTPUT_DIM)
   ) u_front (
      .req_push     (req_push),
      .req_full     (req_full),
      .req_cmd      (req_cmd),
      .req_x_coord  (req_x_coord),
      .req_y_coord  (req_y_coord),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .req_alpha_in (req_alpha_in),
      .src_width    (src_width_ff),
      .src_height   (src_height_ff),
      .out_width    (out_width_ff),
      .out_height   (out_height_ff),
      .q_push       (q_push),
      .q_data       (q_wdata),
      .q_full       (q_full)
   );

   // work queue between front and back
   nsac_queue #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   // execution and result
   nsac_back #(
      .MAX_SOURCE_DIM (MAX_SOURCE_DIM),
      .MAX_OUTPUT_DIM (MAX_OUTPUT_DIM)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .out_width     (out_width_ff),
      .out_height    (out_height_ff),
      .q_empty       (q_empty),
      .q_data        (q_rdata),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_pixel_rgb (rsp_pixel_rgb),
      .rsp_status    (rsp_status)
   );

endmodule

// ===== rtl/nsac_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module nsac_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/nsac_queue.sv =====
// short fifo between the front and back parts
// no dependencies
module nsac_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/nsac_front.sv =====
// front part: accepts requests, range checks them, forms store address and
// scaled coordinate products, and pushes at most one work entry to the queue
// depends on nsac_pkg
module nsac_front #(
   parameter int MAX_SOURCE_DIM = nsac_pkg::MAX_SOURCE_DIM_DEF,
   parameter int MAX_OUTPUT_DIM = nsac_pkg::MAX_OUTPUT_DIM_DEF,
   localparam int SDW = $clog2(MAX_SOURCE_DIM + 1),
   localparam int ODW = $clog2(MAX_OUTPUT_DIM + 1),
   localparam int AW  = (MAX_SOURCE_DIM > 1) ? $clog2(MAX_SOURCE_DIM * MAX_SOURCE_DIM) : 1,
   localparam int PW  = nsac_pkg::XY_W + SDW,
   localparam int EW  = nsac_pkg::KIND_W + AW + 2 * PW + nsac_pkg::RGBA_W
) (
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [nsac_pkg::CMD_W-1:0]   req_cmd,
   input  logic [nsac_pkg::XY_W-1:0]    req_x_coord,
   input  logic [nsac_pkg::XY_W-1:0]    req_y_coord,
   input  logic [nsac_pkg::CHAN_W-1:0]  req_red_in,
   input  logic [nsac_pkg::CHAN_W-1:0]  req_green_in,
   input  logic [nsac_pkg::CHAN_W-1:0]  req_blue_in,
   input  logic [nsac_pkg::CHAN_W-1:0]  req_alpha_in,
   input  logic [SDW-1:0]               src_width,
   input  logic [SDW-1:0]               src_height,
   input  logic [ODW-1:0]               out_width,
   input  logic [ODW-1:0]               out_height,
   output logic                         q_push,
   output logic [EW-1:0]                q_data,
   input  logic                         q_full
);

   import nsac_pkg::*;

   logic                accept;
   logic                is_fetch;
   logic                in_source;
   logic                in_output;
   logic [KIND_W-1:0]   kind;
   logic [AW-1:0]       store_addr;
   logic [PW-1:0]       prod_x;
   logic [PW-1:0]       prod_y;
   logic [RGBA_W-1:0]   rgba;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign is_fetch = (req_cmd == CMD_FETCH);

   // bounds checks against the sizes in effect
   assign in_source = (32'(req_x_coord) < 32'(src_width)) &&
                      (32'(req_y_coord) < 32'(src_height));
   assign in_output = (32'(req_x_coord) < 32'(out_width)) &&
                      (32'(req_y_coord) < 32'(out_height));

   // classify the request
   always_comb begin
      if (is_fetch) begin
         kind = in_output ? KIND_FETCH : KIND_ERROR;
      end else begin
         kind = KIND_STORE;
      end
   end

   // row-major frame address for a store
   assign store_addr = AW'(32'(req_y_coord) * 32'(MAX_SOURCE_DIM) + 32'(req_x_coord));

   // dividends of the nearest-neighbor mapping
   assign prod_x = PW'(req_x_coord) * PW'(src_width);
   assign prod_y = PW'(req_y_coord) * PW'(src_height);

   assign rgba = {req_red_in, req_green_in, req_blue_in, req_alpha_in};

   // stores outside the source are dropped here
   assign q_push = accept && (is_fetch || in_source);
   assign q_data = {kind, store_addr, prod_x, prod_y, rgba};

endmodule

// ===== rtl/nsac_back.sv =====
// back part: writes stores to the frame ram, divides the scaled coordinates,
// reads the source pixel, blends it over the background and holds the result
// depends on nsac_pkg, nsac_ram
module nsac_back #(
   parameter int MAX_SOURCE_DIM = nsac_pkg::MAX_SOURCE_DIM_DEF,
   parameter int MAX_OUTPUT_DIM = nsac_pkg::MAX_OUTPUT_DIM_DEF,
   localparam int SDW = $clog2(MAX_SOURCE_DIM + 1),
   localparam int ODW = $clog2(MAX_OUTPUT_DIM + 1),
   localparam int AW  = (MAX_SOURCE_DIM > 1) ? $clog2(MAX_SOURCE_DIM * MAX_SOURCE_DIM) : 1,
   localparam int PW  = nsac_pkg::XY_W + SDW,
   localparam int EW  = nsac_pkg::KIND_W + AW + 2 * PW + nsac_pkg::RGBA_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ODW-1:0]              out_width,
   input  logic [ODW-1:0]              out_height,
   input  logic                        q_empty,
   input  logic [EW-1:0]               q_data,
   output logic                        q_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [nsac_pkg::RGB_W-1:0]  rsp_pixel_rgb,
   output logic                        rsp_status
);

   import nsac_pkg::*;

   // quotient bits, divider width and step counter width
   localparam int QW  = (MAX_SOURCE_DIM > 1) ? $clog2(MAX_SOURCE_DIM) : 1;
   localparam int DW  = ((PW > ODW + QW) ? PW : ODW + QW) + 1;
   localparam int CNW = (QW > 1) ? $clog2(QW) : 1;

   // entry layout
   localparam int RGBA_LSB = 0;
   localparam int PY_LSB   = RGBA_W;
   localparam int PX_LSB   = PY_LSB + PW;
   localparam int ADDR_LSB = PX_LSB + PW;
   localparam int KIND_LSB = ADDR_LSB + AW;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_ADDR  = 3'd2;
   localparam logic [2:0] ST_BLEND = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   function automatic logic [CHAN_W-1:0] div255(input logic [15:0] s);
      logic [16:0] t;
      t = 17'(s) + 17'd1 + 17'(s[15:8]);
      return t[15:8];
   endfunction

   logic [2:0]          state_ff, state_in;
   logic [CNW-1:0]      cnt_ff, cnt_in;
   logic [DW-1:0]       rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [DW-1:0]       dvs_x_ff, dvs_x_in, dvs_y_ff, dvs_y_in;
   logic [QW-1:0]       quo_x_ff, quo_x_in, quo_y_ff, quo_y_in;
   logic [15:0]         sum_r_ff, sum_r_in, sum_g_ff, sum_g_in, sum_b_ff, sum_b_in;
   logic                out_valid_ff, out_valid_in;
   logic [RGB_W-1:0]    out_rgb_ff, out_rgb_in;
   logic                out_status_ff, out_status_in;

   logic [KIND_W-1:0]   e_kind;
   logic [AW-1:0]       e_addr;
   logic [PW-1:0]       e_px, e_py;
   logic [RGBA_W-1:0]   e_rgba;
   logic                out_free;
   logic                out_load;
   logic                ge_x, ge_y;
   logic                wr_en;
   logic [AW-1:0]       rd_addr;
   logic [RGBA_W-1:0]   rd_data;
   logic [CHAN_W-1:0]   pix_a, pix_inv;

   // unpack the queue head
   assign e_kind = q_data[KIND_LSB +: KIND_W];
   assign e_addr = q_data[ADDR_LSB +: AW];
   assign e_px   = q_data[PX_LSB +: PW];
   assign e_py   = q_data[PY_LSB +: PW];
   assign e_rgba = q_data[RGBA_LSB +: RGBA_W];

   assign out_free = !out_valid_ff || rsp_pop;

   // restoring divide compares, one quotient bit per cycle
   assign ge_x = (rem_x_ff >= dvs_x_ff);
   assign ge_y = (rem_y_ff >= dvs_y_ff);

   // frame ram
   assign wr_en   = q_pop && (e_kind == KIND_STORE);
   assign rd_addr = AW'(32'(quo_y_ff) * 32'(MAX_SOURCE_DIM) + 32'(quo_x_ff));

   nsac_ram #(
      .WIDTH (RGBA_W),
      .DEPTH (MAX_SOURCE_DIM * MAX_SOURCE_DIM)
   ) u_frame (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (e_addr),
      .wr_data (e_rgba),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign pix_a   = rd_data[7:0];
   assign pix_inv = FULL_ALPHA - pix_a;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rem_x_in      = rem_x_ff;
      rem_y_in      = rem_y_ff;
      dvs_x_in      = dvs_x_ff;
      dvs_y_in      = dvs_y_ff;
      quo_x_in      = quo_x_ff;
      quo_y_in      = quo_y_ff;
      sum_r_in      = sum_r_ff;
      sum_g_in      = sum_g_ff;
      sum_b_in      = sum_b_ff;
      q_pop         = 1'b0;
      out_load      = 1'b0;
      out_rgb_in    = out_rgb_ff;
      out_status_in = out_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               case (e_kind)
                  KIND_STORE: begin
                     q_pop = 1'b1;
                  end
                  KIND_ERROR: begin
                     if (out_free) begin
                        q_pop         = 1'b1;
                        out_load      = 1'b1;
                        out_rgb_in    = '0;
                        out_status_in = STATUS_RANGE;
                     end
                  end
                  KIND_FETCH: begin
                     q_pop    = 1'b1;
                     rem_x_in = DW'(e_px);
                     rem_y_in = DW'(e_py);
                     dvs_x_in = DW'(out_width) << (QW - 1);
                     dvs_y_in = DW'(out_height) << (QW - 1);
                     quo_x_in = '0;
                     quo_y_in = '0;
                     cnt_in   = CNW'(QW - 1);
                     state_in = ST_DIV;
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_DIV: begin
            rem_x_in = ge_x ? rem_x_ff - dvs_x_ff : rem_x_ff;
            rem_y_in = ge_y ? rem_y_ff - dvs_y_ff : rem_y_ff;
            quo_x_in = QW'({quo_x_ff, ge_x});
            quo_y_in = QW'({quo_y_ff, ge_y});
            dvs_x_in = dvs_x_ff >> 1;
            dvs_y_in = dvs_y_ff >> 1;
            if (cnt_ff == '0) begin
               state_in = ST_ADDR;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_ADDR: begin
            // frame read address is stable, data arrives next cycle
            state_in = ST_BLEND;
         end
         ST_BLEND: begin
            sum_r_in = 16'(rd_data[31:24]) * 16'(pix_a) + 16'(BG_RED) * 16'(pix_inv);
            sum_g_in = 16'(rd_data[23:16]) * 16'(pix_a) + 16'(BG_GREEN) * 16'(pix_inv);
            sum_b_in = 16'(rd_data[15:8]) * 16'(pix_a) + 16'(BG_BLUE) * 16'(pix_inv);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_rgb_in    = {div255(sum_r_ff), div255(sum_g_ff), div255(sum_b_ff)};
               out_status_in = STATUS_OK;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result holding register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      rem_x_ff      <= rem_x_in;
      rem_y_ff      <= rem_y_in;
      dvs_x_ff      <= dvs_x_in;
      dvs_y_ff      <= dvs_y_in;
      quo_x_ff      <= quo_x_in;
      quo_y_ff      <= quo_y_in;
      sum_r_ff      <= sum_r_in;
      sum_g_ff      <= sum_g_in;
      sum_b_ff      <= sum_b_in;
      out_rgb_ff    <= out_rgb_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_pixel_rgb = out_rgb_ff;
   assign rsp_status    = out_status_ff;

endmodule

// ===== tb/nearest_scale_alpha_composite_core_tb.sv =====
`timescale 1ns / 1ps
// testbench for nearest_scale_alpha_composite_core: pixel stores and fetches under random idling
// a predictor class mirrors the frame store, the scaling and the blend, and checks each fetch
// depends on nsac_pkg and the core rtl
module nearest_scale_alpha_composite_core_tb;
   import nsac_pkg::*;

   localparam int SRC_DIM          = MAX_SOURCE_DIM_DEF;
   localparam int OUT_DIM          = MAX_OUTPUT_DIM_DEF;
   localparam int SETTLE_CYCLES    = 40;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int NUM_PHASES       = 9;
   localparam int PRESSURE_PHASE   = 4;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [XY_W-1:0]   x;
      logic [XY_W-1:0]   y;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } pixel_request_type;

   typedef struct {
      logic [RGB_W-1:0] rgb;
      logic             status;
   } pixel_result_type;

   // frame store copy, scaling and blend; holds the fetch results still owed
   class composite_predictor;
      logic [RGBA_W-1:0] frame [int unsigned];
      int unsigned       src_w, src_h, out_w, out_h;
      pixel_result_type  pending_pixels [$];
      int                mismatches;

      function new();
         src_w      = DIM_RESET;
         src_h      = DIM_RESET;
         out_w      = DIM_RESET;
         out_h      = DIM_RESET;
         mismatches = 0;
      endfunction

      function int unsigned clamp(int unsigned v, int unsigned top);
         if (v < 1) return 1;
         if (v > top) return top;
         return v;
      endfunction

      function void write_size(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
         case (idx)
            CSR_SOURCE_WIDTH:  src_w = clamp(32'(data[SRC_CFG_W-1:0]), SRC_DIM);
            CSR_SOURCE_HEIGHT: src_h = clamp(32'(data[SRC_CFG_W-1:0]), SRC_DIM);
            CSR_OUTPUT_WIDTH:  out_w = clamp(32'(data[OUT_CFG_W-1:0]), OUT_DIM);
            CSR_OUTPUT_HEIGHT: out_h = clamp(32'(data[OUT_CFG_W-1:0]), OUT_DIM);
            default: ;
         endcase
      endfunction

      // nearest source entry for an in-range output coordinate
      function int unsigned source_addr(int unsigned x, int unsigned y);
         return (y * src_h / out_h) * SRC_DIM + x * src_w / out_w;
      endfunction

      function bit stored(int unsigned addr);
         return frame.exists(addr);
      endfunction

      function logic [CHAN_W-1:0] mix(logic [CHAN_W-1:0] c, logic [CHAN_W-1:0] a,
                                      logic [CHAN_W-1:0] bg);
         int unsigned s;
         s = 32'(c) * 32'(a) + 32'(bg) * (32'(FULL_ALPHA) - 32'(a));
         return CHAN_W'(s / 32'(FULL_ALPHA));
      endfunction

      function void note_request(pixel_request_type q);
         pixel_result_type  res;
         logic [RGBA_W-1:0] p;
         int unsigned       addr;
         // store: dropped when outside the source image
         if (q.cmd == CMD_STORE) begin
            if (q.x < src_w && q.y < src_h)
               frame[32'(q.y) * SRC_DIM + 32'(q.x)] = {q.red, q.green, q.blue, q.alpha};
            return;
         end
         // fetch: range error or blended source pixel
         if (q.x >= out_w || q.y >= out_h) begin
            res.rgb    = '0;
            res.status = STATUS_RANGE;
         end else begin
            addr       = source_addr(32'(q.x), 32'(q.y));
            p          = frame.exists(addr) ? frame[addr] : '0;
            res.rgb    = {mix(p[31:24], p[7:0], BG_RED), mix(p[23:16], p[7:0], BG_GREEN),
                          mix(p[15:8], p[7:0], BG_BLUE)};
            res.status = STATUS_OK;
         end
         pending_pixels.push_back(res);
      endfunction

      function void check_pixel(logic [RGB_W-1:0] rgb, logic status);
         pixel_result_type exp_px;
         if (pending_pixels.size() == 0) begin
            $error("pixel transfer with none expected: rgb %06h status %0d", rgb, status);
            mismatches++;
            return;
         end
         exp_px = pending_pixels.pop_front();
         if (rgb !== exp_px.rgb) begin
            $error("pixel_rgb: expected %06h, got %06h", exp_px.rgb, rgb);
            mismatches++;
         end
         if (status !== exp_px.status) begin
            $error("status: expected %0d, got %0d", exp_px.status, status);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_push;
   logic                 req_full;
   logic [CMD_W-1:0]     req_cmd;
   logic [XY_W-1:0]      req_x_coord;
   logic [XY_W-1:0]      req_y_coord;
   logic [CHAN_W-1:0]    req_red_in;
   logic [CHAN_W-1:0]    req_green_in;
   logic [CHAN_W-1:0]    req_blue_in;
   logic [CHAN_W-1:0]    req_alpha_in;
   logic                 rsp_empty;
   logic                 rsp_pop;
   logic [RGB_W-1:0]     rsp_pixel_rgb;
   logic                 rsp_status;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   composite_predictor pred;
   bit                 hold_rsp;

   nearest_scale_alpha_composite_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_cmd       (req_cmd),
      .req_x_coord   (req_x_coord),
      .req_y_coord   (req_y_coord),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .req_alpha_in  (req_alpha_in),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_pixel_rgb (rsp_pixel_rgb),
      .rsp_status    (rsp_status),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle lengths: mostly short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 2);
      if (r < 92) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic int sender_gap();
      if ($urandom_range(0, 99) < 55) return 0;
      return pick_gap();
   endfunction

   function automatic logic [CHAN_W-1:0] pick_alpha();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return '0;
      if (r < 25) return FULL_ALPHA;
      return CHAN_W'($urandom);
   endfunction

   function automatic pixel_request_type make_request(logic [CMD_W-1:0] cmd, int x, int y,
                                                      logic [RGBA_W-1:0] rgba);
      pixel_request_type q;
      q.cmd   = cmd;
      q.x     = XY_W'(x);
      q.y     = XY_W'(y);
      {q.red, q.green, q.blue, q.alpha} = rgba;
      return q;
   endfunction

   // one request transfer, entered and left at a falling edge
   task automatic send_request(pixel_request_type q, int gap);
      if (gap > 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push     = 1'b1;
      req_cmd      = q.cmd;
      req_x_coord  = q.x;
      req_y_coord  = q.y;
      req_red_in   = q.red;
      req_green_in = q.green;
      req_blue_in  = q.blue;
      req_alpha_in = q.alpha;
      do @(posedge clock); while (req_full);
      pred.note_request(q);
      @(negedge clock);
   endtask

   // all four size registers, in index order
   task automatic write_sizes(logic [CSR_DAT_W-1:0] sw, logic [CSR_DAT_W-1:0] sh,
                              logic [CSR_DAT_W-1:0] ow, logic [CSR_DAT_W-1:0] oh);
      logic [CSR_IDX_W-1:0] regs [4] = '{CSR_SOURCE_WIDTH, CSR_SOURCE_HEIGHT,
                                         CSR_OUTPUT_WIDTH, CSR_OUTPUT_HEIGHT};
      logic [CSR_DAT_W-1:0] vals [4];
      vals = '{sw, sh, ow, oh};
      foreach (regs[i]) begin
         csr_valid = 1'b1;
         csr_index = regs[i];
         csr_wdata = vals[i];
         do @(posedge clock); while (!csr_ready);
         pred.write_size(csr_index, csr_wdata);
         @(negedge clock);
      end
      csr_valid = 1'b0;
   endtask

   // stop sending until every owed result has come, then let stores finish
   task automatic wait_idle();
      req_push = 1'b0;
      while (pred.pending_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // random item; a fetch of an unwritten source pixel is preceded by a store to it
   task automatic random_request(int gap);
      pixel_request_type q;
      pixel_request_type fill;
      int                r;
      int unsigned       addr;
      r       = $urandom_range(0, 99);
      q.red   = CHAN_W'($urandom);
      q.green = CHAN_W'($urandom);
      q.blue  = CHAN_W'($urandom);
      q.alpha = pick_alpha();
      if (r < 18) begin
         q.cmd = CMD_STORE;
         q.x   = XY_W'($urandom_range(0, pred.src_w - 1));
         q.y   = XY_W'($urandom_range(0, pred.src_h - 1));
      end else if (r < 24) begin
         // store outside the source image
         q.cmd = CMD_STORE;
         if ($urandom_range(0, 1)) begin
            q.x = XY_W'($urandom_range(pred.src_w, OUT_DIM - 1));
            q.y = XY_W'($urandom_range(0, OUT_DIM - 1));
         end else begin
            q.x = XY_W'($urandom_range(0, OUT_DIM - 1));
            q.y = XY_W'($urandom_range(pred.src_h, OUT_DIM - 1));
         end
      end else if (r < 32 && (pred.out_w < OUT_DIM || pred.out_h < OUT_DIM)) begin
         // fetch outside the output image
         q.cmd = CMD_FETCH;
         if (pred.out_w < OUT_DIM && (pred.out_h == OUT_DIM || $urandom_range(0, 1))) begin
            q.x = XY_W'($urandom_range(pred.out_w, OUT_DIM - 1));
            q.y = XY_W'($urandom_range(0, OUT_DIM - 1));
         end else begin
            q.x = XY_W'($urandom_range(0, OUT_DIM - 1));
            q.y = XY_W'($urandom_range(pred.out_h, OUT_DIM - 1));
         end
      end else begin
         q.cmd = CMD_FETCH;
         q.x   = XY_W'($urandom_range(0, pred.out_w - 1));
         q.y   = XY_W'($urandom_range(0, pred.out_h - 1));
         addr  = pred.source_addr(32'(q.x), 32'(q.y));
         if (!pred.stored(addr)) begin
            fill = make_request(CMD_STORE, int'(addr % SRC_DIM), int'(addr / SRC_DIM),
                                $urandom);
            fill.alpha = pick_alpha();
            send_request(fill, gap);
            gap = 0;
         end
      end
      send_request(q, gap);
   endtask

   // result side: random pop idling, long hold on request, steady stretches
   initial begin
      int idle_left;
      int steady_left;
      rsp_pop     = 1'b0;
      idle_left   = 0;
      steady_left = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) pred.check_pixel(rsp_pixel_rgb, rsp_status);
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp  = 1'b0;
            idle_left = LONG_HOLD_CYCLES;
         end
         if (idle_left > 0) begin
            rsp_pop = 1'b0;
            idle_left--;
         end else begin
            rsp_pop = 1'b1;
            if (steady_left > 0) steady_left--;
            else if ($urandom_range(0, 99) < 3) steady_left = $urandom_range(50, 150);
            else if ($urandom_range(0, 3) == 0) idle_left = pick_gap();
         end
      end
   end

   // stimulus
   initial begin
      logic [CSR_DAT_W-1:0] phase_sizes [NUM_PHASES][4];
      int                   phase_items [NUM_PHASES];
      bit                   steady;

      phase_sizes = '{
         '{12'd4, 12'd3, 12'd7, 12'd5},
         '{12'd1, 12'd1, 12'd2048, 12'd2048},
         '{12'd256, 12'd256, 12'd1, 12'd1},
         '{12'd0, 12'h3FF, 12'd0, 12'hFFF},
         '{12'd16, 12'd16, 12'd100, 12'd37},
         '{12'h200, 12'd257, 12'd2049, 12'hFFF},
         '{12'd256, 12'd256, 12'd2048, 12'd2048},
         '{12'd9, 12'd200, 12'd3, 12'd2048},
         '{12'd33, 12'd5, 12'd33, 12'd5}
      };
      phase_items = '{110, 70, 50, 70, 110, 60, 110, 70, 120};

      pred         = new();
      hold_rsp     = 1'b0;
      reset        = 1'b1;
      req_push     = 1'b0;
      req_cmd      = CMD_STORE;
      req_x_coord  = '0;
      req_y_coord  = '0;
      req_red_in   = '0;
      req_green_in = '0;
      req_blue_in  = '0;
      req_alpha_in = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_SOURCE_WIDTH;
      csr_wdata    = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: corners, opaque, transparent, half alpha, dropped stores, range errors
      send_request(make_request(CMD_STORE, 0, 0, 32'hFF0080FF), 0);
      send_request(make_request(CMD_STORE, 255, 255, 32'h12345600), 0);
      send_request(make_request(CMD_STORE, 255, 0, 32'hFFFFFF80), 0);
      send_request(make_request(CMD_STORE, 0, 255, 32'hFFFFFFFF), 0);
      send_request(make_request(CMD_STORE, 128, 64, 32'h000000FF), 1);
      send_request(make_request(CMD_STORE, 1, 1, 32'hA55AC37F), 0);
      send_request(make_request(CMD_STORE, 256, 0, 32'h11111111), 0);
      send_request(make_request(CMD_STORE, 0, 256, 32'h22222222), 0);
      send_request(make_request(CMD_STORE, 2047, 2047, 32'h33333333), 0);
      send_request(make_request(CMD_FETCH, 0, 0, 32'hFFFFFFFF), 0);
      send_request(make_request(CMD_FETCH, 255, 255, 32'h0), 0);
      send_request(make_request(CMD_FETCH, 255, 0, 32'h0), 2);
      send_request(make_request(CMD_FETCH, 0, 255, 32'h0), 0);
      send_request(make_request(CMD_FETCH, 128, 64, 32'h0), 0);
      send_request(make_request(CMD_FETCH, 1, 1, 32'hFFFFFFFF), 0);
      send_request(make_request(CMD_FETCH, 256, 0, 32'h0), 0);
      send_request(make_request(CMD_FETCH, 0, 256, 32'h0), 0);
      send_request(make_request(CMD_FETCH, 2047, 2047, 32'h0), 0);
      wait_idle();

      // random phases, each under its own size setting
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_sizes(phase_sizes[p][0], phase_sizes[p][1], phase_sizes[p][2], phase_sizes[p][3]);
         steady = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < phase_items[p]; n++) begin
            if (p == PRESSURE_PHASE && n == 40) begin
               // receiver holds off while requests keep coming, then sender drains
               hold_rsp = 1'b1;
               repeat (24) random_request(0);
               wait_idle();
            end
            random_request(steady ? 0 : sender_gap());
         end
         wait_idle();
      end

      if (pred.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // run limit
   initial begin
      #10ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
